// ===== rtl/core/windowed_pulse_flow_meter_macros.svh =====
// ---------------------------------------------------------------------------
// windowed_pulse_flow_meter assertion macros
// shared concurrent assertion forms for the flow meter
// ---------------------------------------------------------------------------
`ifndef WINDOWED_PULSE_FLOW_METER_MACROS_SVH
`define WINDOWED_PULSE_FLOW_METER_MACROS_SVH

// same-cycle implication
`define WPFM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("windowed_pulse_flow_meter assertion failed");

// next-cycle implication
`define WPFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("windowed_pulse_flow_meter assertion failed");

`endif

// ===== rtl/core/wpfm_pkg.sv =====
// ---------------------------------------------------------------------------
// wpfm_pkg
// types and constants shared by the windowed pulse flow meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpfm_pkg;

   localparam int RING_DEPTH = 32;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int Q_W     = 32;
   localparam int NUM_W   = CNT_W + 32;
   localparam int M_W     = CNT_W + 16;
   localparam int DEN_W   = 48;
   localparam int STEP_W  = $clog2(Q_W);
   localparam int WP_W    = 6;
   localparam int TOTAL_W = 32;
   localparam int RSP_W   = 72;
   localparam int PAD_W   = RSP_W - Q_W - WP_W - TOTAL_W;

   localparam logic [CFG_W-1:0] MS_PER_MINUTE = 16'd60000;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic REG_WINDOW_MS = 1'b0;
   localparam logic REG_PPL       = 1'b1;

   localparam logic [CFG_W-1:0] WINDOW_RST = 16'd1000;
   localparam logic [CFG_W-1:0] PPL_RST    = 16'd450;

   localparam logic CMD_PULSE  = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_ms;
      logic [CFG_W-1:0] pulses_per_litre;
   } cfg_type;

   typedef struct packed {
      logic pulse_wr;
      logic upd_start;
      logic walk_rd;
      logic mul;
      logic div_init;
      logic div_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic walk_last;
   } dp_sts_type;

endpackage

// ===== rtl/core/windowed_pulse_flow_meter.sv =====
// ---------------------------------------------------------------------------
// windowed_pulse_flow_meter
// flow meter over pulse timestamps in a sliding millisecond window
// ---------------------------------------------------------------------------
// A pulse item (tuser 0) stores its time in a 32-entry ring and bumps the
// wrapping total; the block is ready again the next cycle. An update item
// (tuser 1) scans the stored times one per cycle through the ring memory's
// read port, then runs a one-bit-per-cycle divider for the Q16.16 rate and
// waits until the result register is free. The result register holds one
// finished item while the next input item is accepted.
`timescale 1ns / 1ps

`include "windowed_pulse_flow_meter_macros.svh"

module windowed_pulse_flow_meter (
   input  logic                         clock,
   input  logic                         reset,
   // tdata: time_ms[31:0]
   input  logic [wpfm_pkg::TIME_W-1:0]  req_tdata,
   // tuser: command
   input  logic                         req_tuser,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata: flow_rate_q16[31:0], window_pulses[37:32], total_pulses[69:38], zero pad
   output logic [wpfm_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [wpfm_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [wpfm_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [wpfm_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   import wpfm_pkg::*;

   cfg_type              cfg;
   dp_cmd_type           cmd;
   dp_sts_type           sts;
   logic [Q_W-1:0]       flow_rate_q16;
   logic [WP_W-1:0]      window_pulses;
   logic [TOTAL_W-1:0]   total_pulses;

   wpfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wpfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wpfm_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_time      (req_tdata),
      .sts           (sts),
      .flow_rate_q16 (flow_rate_q16),
      .window_pulses (window_pulses),
      .total_pulses  (total_pulses)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, total_pulses, window_pulses, flow_rate_q16};

   // datapath commands never overlap
   `WPFM_ASSERT_IMPLY(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd))
   // an update keeps the input side closed on the next cycle
   `WPFM_ASSERT_NEXT(a_upd_busy, clock, reset,
      req_tvalid && req_tready && (req_tuser == CMD_UPDATE), !req_tready)
   // a new result never overwrites one still waiting
   `WPFM_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready)

endmodule

// ===== rtl/core/wpfm_ram.sv =====
// ---------------------------------------------------------------------------
// wpfm_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpfm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wpfm_csr.sv =====
// ---------------------------------------------------------------------------
// wpfm_csr
// configuration registers behind the apb-style port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpfm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [wpfm_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [wpfm_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [wpfm_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output wpfm_pkg::cfg_type            cfg
);

   import wpfm_pkg::*;

   logic [CFG_W-1:0] window_ff;
   logic [CFG_W-1:0] window_in;
   logic [CFG_W-1:0] ppl_ff;
   logic [CFG_W-1:0] ppl_in;
   logic             wr_en;
   logic             reg_idx;

   assign reg_idx = csr_paddr[2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      window_in = window_ff;
      ppl_in    = ppl_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WINDOW_MS: window_in = csr_pwdata[CFG_W-1:0];
            REG_PPL:       ppl_in    = csr_pwdata[CFG_W-1:0];
            default:       window_in = window_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RST;
         ppl_ff    <= PPL_RST;
      end else begin
         window_ff <= window_in;
         ppl_ff    <= ppl_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WINDOW_MS: csr_prdata = CSR_DW'(window_ff);
         REG_PPL:       csr_prdata = CSR_DW'(ppl_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready           = 1'b1;
   assign cfg.window_ms        = window_ff;
   assign cfg.pulses_per_litre = ppl_ff;

endmodule

// ===== rtl/core/wpfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// wpfm_ctrl
// sequencer for pulse writes, ring walk, rate division and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  wpfm_pkg::dp_sts_type   sts,
   output wpfm_pkg::dp_cmd_type   cmd
);

   import wpfm_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_PULSE) begin
                  cmd.pulse_wr = 1'b1;
               end else begin
                  cmd.upd_start = 1'b1;
                  state_in      = sts.cnt_zero ? ST_MUL : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk_rd = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(Q_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/wpfm_dp.sv =====
// ---------------------------------------------------------------------------
// wpfm_dp
// pulse ring, window scan, rate multiply and bit-serial divider
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpfm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  wpfm_pkg::dp_cmd_type          cmd,
   input  wpfm_pkg::cfg_type             cfg,
   input  logic [wpfm_pkg::TIME_W-1:0]   req_time,
   output wpfm_pkg::dp_sts_type          sts,
   output logic [wpfm_pkg::Q_W-1:0]      flow_rate_q16,
   output logic [wpfm_pkg::WP_W-1:0]     window_pulses,
   output logic [wpfm_pkg::TOTAL_W-1:0]  total_pulses
);

   import wpfm_pkg::*;

   // ring bookkeeping
   logic [RING_AW-1:0] slot_ff;
   logic [RING_AW-1:0] slot_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;

   // window scan
   logic [RING_AW-1:0] idx_ff;
   logic [RING_AW-1:0] idx_in;
   logic               rd_vld_ff;
   logic               rd_vld_in;
   logic [TIME_W-1:0]  rd_data;
   logic [TIME_W-1:0]  wstart_ff;
   logic [TIME_W-1:0]  wstart_in;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   n_in;
   logic [TIME_W-1:0]  early_ff;
   logic [TIME_W-1:0]  early_in;
   logic [TIME_W-1:0]  late_ff;
   logic [TIME_W-1:0]  late_in;
   logic               hit;

   // rate arithmetic
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   num_in;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   den_in;
   logic               zero_ff;
   logic               zero_in;
   logic               sat_ff;
   logic               sat_in;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   rem_in;
   logic [Q_W-1:0]     quo_ff;
   logic [Q_W-1:0]     quo_in;
   logic [CNT_W-1:0]   nm1;
   logic [TIME_W-1:0]  delta;
   logic [TIME_W-1:0]  delta_eff;
   logic [CFG_W-1:0]   ppl_eff;
   logic [NUM_W-32-1:0] num_hi;
   logic [DEN_W:0]     trial;
   logic               trial_ge;

   // result register
   logic [Q_W-1:0]     flow_ff;
   logic [Q_W-1:0]     flow_in;
   logic [WP_W-1:0]    wp_ff;
   logic [WP_W-1:0]    wp_in;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [TOTAL_W-1:0] rsp_total_in;

   wpfm_ram #(
      .WIDTH (TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.pulse_wr),
      .wr_addr (slot_ff),
      .wr_data (req_time),
      .rd_en   (cmd.walk_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign sts.cnt_zero  = (count_ff == '0);
   assign sts.walk_last = (CNT_W'(idx_ff) == count_ff - 1'b1);

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      total_in = total_ff;
      if (cmd.pulse_wr) begin
         slot_in  = (slot_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         total_in = total_ff + 1'b1;
         if (count_ff != CNT_W'(RING_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign hit = (rd_data >= wstart_ff);

   always_comb begin
      idx_in    = idx_ff;
      rd_vld_in = cmd.walk_rd;
      wstart_in = wstart_ff;
      n_in      = n_ff;
      early_in  = early_ff;
      late_in   = late_ff;
      if (cmd.upd_start) begin
         idx_in    = '0;
         wstart_in = req_time - TIME_W'(cfg.window_ms);
         n_in      = '0;
         early_in  = '1;
         late_in   = '0;
      end else begin
         if (cmd.walk_rd) begin
            idx_in = idx_ff + 1'b1;
         end
         if (rd_vld_ff && hit) begin
            n_in = n_ff + 1'b1;
            if (rd_data < early_ff) begin
               early_in = rd_data;
            end
            if (rd_data > late_ff) begin
               late_in = rd_data;
            end
         end
      end
   end

   assign nm1       = n_ff - 1'b1;
   assign delta     = late_ff - early_ff;
   assign delta_eff = (delta == '0) ? TIME_W'(1) : delta;
   assign ppl_eff   = (cfg.pulses_per_litre == '0) ? CFG_W'(1) : cfg.pulses_per_litre;
   assign num_hi    = num_ff[NUM_W-1:Q_W];
   assign trial     = {rem_ff, quo_ff[Q_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.mul) begin
         num_in  = {M_W'(nm1) * M_W'(MS_PER_MINUTE), 16'h0000};
         den_in  = DEN_W'(ppl_eff) * DEN_W'(delta_eff);
         zero_in = (n_ff < CNT_W'(2));
      end
      if (cmd.div_init) begin
         // quotient fits in q_w bits only when the upper numerator part is below den
         sat_in = (DEN_W'(num_hi) >= den_ff);
         rem_in = DEN_W'(num_hi);
         quo_in = num_ff[Q_W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], trial_ge};
      end
   end

   always_comb begin
      flow_in      = flow_ff;
      wp_in        = wp_ff;
      rsp_total_in = rsp_total_ff;
      if (cmd.out_load) begin
         flow_in      = zero_ff ? '0 : (sat_ff ? '1 : quo_ff);
         wp_in        = WP_W'(n_ff);
         rsp_total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         slot_ff   <= slot_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wstart_ff    <= wstart_in;
      n_ff         <= n_in;
      early_ff     <= early_in;
      late_ff      <= late_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      flow_ff      <= flow_in;
      wp_ff        <= wp_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign flow_rate_q16 = flow_ff;
   assign window_pulses = wp_ff;
   assign total_pulses  = rsp_total_ff;

endmodule
